[rtl/core/uho_pkg.sv]
// Package for the unit hydrograph ordinate generator.
// Holds the beat types, FSM state type and fixed constants; no dependencies.
`default_nettype none
package uho_pkg;
    typedef struct packed {
        logic        action;
        logic [15:0] x4_days;
    } uho_in_t;

    typedef struct packed {
        logic [16:0] ordinate;
        logic [5:0]  position;
        logic        last;
    } uho_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_POINT,
        ST_MUL_U,
        ST_SQRT,
        ST_MUL_U2,
        ST_MUL_P,
        ST_EMIT
    } uho_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic point;
        logic mul_u;
        logic sqrt_start;
        logic sqrt_step;
        logic mul_u2;
        logic mul_p;
        logic emit;
    } uho_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic direct;
        logic last_pt;
    } uho_sts_t;

    localparam int WFRAC     = 23;
    localparam int X4_MAX    = 32768;
    localparam int DIV_STEPS = 34;
    localparam int SQRT_STEPS = 24;
endpackage
`default_nettype wire

[rtl/core/uho_ctrl.sv]
// Controller FSM for the ordinate generator.
// Depends on uho_pkg; drives commands to uho_dp and reads its status.
`default_nettype none
module uho_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire uho_pkg::uho_sts_t sts,
    output uho_pkg::uho_cmd_t   cmd,
    output logic                busy
);
    import uho_pkg::*;

    uho_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_POINT;
                end
            end
            ST_POINT:
            begin
                cmd.point = 1'b1;
                state_next = ST_MUL_U;
            end
            ST_MUL_U:
            begin
                cmd.mul_u = 1'b1;
                // skip the power path when S is fixed for this point
                state_next = sts.direct ? ST_EMIT : ST_SQRT;
                cmd.sqrt_start = !sts.direct;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_done)
                begin
                    state_next = ST_MUL_U2;
                end
            end
            ST_MUL_U2:
            begin
                cmd.mul_u2 = 1'b1;
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.mul_p = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                state_next = sts.last_pt ? ST_IDLE : ST_POINT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    property p_emit_after_work;
        @(posedge clk) disable iff (!rst_n)
        cmd.emit |-> ($past(state_reg) == ST_MUL_P || $past(state_reg) == ST_MUL_U);
    endproperty
    a_emit_after_work: assert property (p_emit_after_work) else $error("emit order");

    property p_load_idle;
        @(posedge clk) disable iff (!rst_n)
        cmd.load |=> busy;
    endproperty
    a_load_idle: assert property (p_load_idle) else $error("load not busy");

    property p_last_idle;
        @(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.last_pt) |=> !busy;
    endproperty
    a_last_idle: assert property (p_last_idle) else $error("no idle after last");
endmodule
`default_nettype wire

[rtl/core/uho_dp.sv]
// Datapath: reciprocal divider, square root unit, multipliers, S and ordinate.
// Depends on uho_pkg; sequenced by uho_ctrl.
`default_nettype none
module uho_dp #(
    parameter int MAX_ORDINATES = 64,
    parameter int ORD_FRAC_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire uho_pkg::uho_in_t  din,
    input  wire uho_pkg::uho_cmd_t cmd,
    output uho_pkg::uho_sts_t      sts,
    output uho_pkg::uho_out_t      dout,
    output logic                   strobe
);
    import uho_pkg::*;

    localparam int SH = (ORD_FRAC_BITS < 24) ? 24 - ORD_FRAC_BITS : 0;
    localparam int SW = ORD_FRAC_BITS + 2;
    localparam logic [SW-1:0] ONE_OUT = SW'(((64'd1 << 24) + ((SH > 0) ?
        (64'd1 << (SH - 1)) : 64'd0)) >> SH);

    logic        kind_reg;
    logic [15:0] raw_reg;
    logic        single_reg;
    logic [6:0]  len_reg;
    logic [5:0]  k_reg;
    logic [23:0] recip_reg;
    // divider
    logic [33:0] dq_reg;
    logic [16:0] drem_reg;
    logic [5:0]  dcnt_reg;
    // point
    logic [6:0]  t_reg;
    logic [1:0]  seg_reg;   // 0 fixed one, 1 kind0, 2 rising, 3 falling
    logic [23:0] u_reg;
    // sqrt of u<<23 (47 bits)
    logic [47:0] sv_reg;
    logic [47:0] sres_reg;
    logic [4:0]  scnt_reg;
    logic [23:0] u2_reg;
    logic [24:0] s24_reg;
    logic [SW-1:0] prev_reg;
    logic        strobe_reg;
    uho_out_t    out_reg;

    logic [15:0] raw_sat;
    logic        single_w;
    logic [6:0]  len_w;
    logic [16:0] dtrial;
    logic [30:0] prod_u;
    logic [23:0] uc;
    logic [47:0] sbit;
    logic [47:0] ssum;
    logic [47:0] u2_full;
    logic [47:0] p_full;
    logic [23:0] pw;
    logic [SW-1:0] s_out;
    logic [24:0] s_add;
    logic        is_last;
    logic [16:0] x2;

    assign raw_sat  = (din.x4_days > 16'(X4_MAX)) ? 16'(X4_MAX) : din.x4_days;
    assign single_w = din.action ? (raw_sat <= 16'd512) : (raw_sat <= 16'd1024);

    always_comb
    begin
        logic [6:0] base;
        base = 7'((17'(raw_sat) + 17'd1023) >> 10);
        if (single_w)
            len_w = 7'd1;
        else if (din.action)
            len_w = 7'(base << 1);
        else
            len_w = base;
        if (len_w > 7'(MAX_ORDINATES))
            len_w = 7'(MAX_ORDINATES);
    end

    assign dtrial = {drem_reg[15:0], dq_reg[33]};
    assign is_last = (7'(k_reg) + 7'd1 == len_reg);
    assign x2 = {raw_reg, 1'b0};
    assign prod_u = 31'(t_reg) * 31'(recip_reg);
    // rising part uses u, falling part uses 2 - u
    always_comb
    begin
        logic [30:0] two;
        two = 31'd2 << WFRAC;
        if (seg_reg == 2'd3)
            uc = (prod_u < two) ? 24'(two - prod_u) : 24'd0;
        else
            uc = 24'(prod_u);
        if (uc > 24'(1 << WFRAC))
            uc = 24'(1 << WFRAC);
    end
    assign sbit = 48'd1 << (2 * (SQRT_STEPS - 1 - 32'(scnt_reg)));
    assign ssum = sres_reg + sbit;
    assign u2_full = 48'(u_reg) * 48'(u_reg);
    assign p_full = 48'(u2_reg) * 48'(sres_reg[23:0]);
    assign pw = 24'(p_full >> WFRAC);

    always_comb
    begin
        s_add = s24_reg + 25'(SH > 0 ? (64'd1 << (SH - 1)) : 64'd0);
        s_out = is_last ? ONE_OUT : SW'(s_add >> SH);
    end

    assign sts.div_done  = (dcnt_reg == 6'(DIV_STEPS - 1));
    assign sts.sqrt_done = (scnt_reg == 5'(SQRT_STEPS - 1));
    assign sts.direct    = (seg_reg == 2'd0);
    assign sts.last_pt   = is_last;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= din.action;
            raw_reg    <= raw_sat;
            single_reg <= single_w;
            len_reg    <= len_w;
            prev_reg   <= '0;
        end
        if (cmd.div_start)
        begin
            dq_reg   <= 34'd1 << 33;
            drem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            // restoring division 2^33 / raw, one quotient bit per cycle
            if (dtrial >= 17'(raw_reg))
            begin
                drem_reg <= dtrial - 17'(raw_reg);
                dq_reg   <= {dq_reg[32:0], 1'b1};
            end
            else
            begin
                drem_reg <= dtrial;
                dq_reg   <= {dq_reg[32:0], 1'b0};
            end
            if (sts.div_done)
                recip_reg <= single_reg ? 24'd0 : 24'({dq_reg[32:0],
                    (dtrial >= 17'(raw_reg))});
        end
        if (cmd.point)
        begin
            t_reg <= 7'(k_reg) + 7'd1;
        end
        if (cmd.mul_u)
        begin
            u_reg <= uc;
            if (seg_reg == 2'd0)
                s24_reg <= 25'd1 << 24;
        end
        if (cmd.sqrt_start)
        begin
            sv_reg <= 48'(uc) << WFRAC;
            sres_reg <= '0;
        end
        if (cmd.sqrt_step)
        begin
            if (sv_reg >= ssum)
            begin
                sv_reg <= sv_reg - ssum;
                sres_reg <= (sres_reg >> 1) + sbit;
            end
            else
            begin
                sres_reg <= sres_reg >> 1;
            end
        end
        if (cmd.mul_u2)
            u2_reg <= 24'(u2_full >> WFRAC);
        if (cmd.mul_p)
        begin
            if (seg_reg == 2'd1)
                s24_reg <= {pw, 1'b0};
            else if (seg_reg == 2'd2)
                s24_reg <= 25'(pw);
            else
                s24_reg <= (25'd1 << 24) - 25'(pw);
        end
        if (cmd.emit)
        begin
            out_reg.ordinate <= 17'((s_out >= prev_reg) ? s_out - prev_reg : '0);
            out_reg.position <= k_reg;
            out_reg.last     <= is_last;
            prev_reg         <= s_out;
        end
    end

    // segment select, computed the cycle t is latched
    always_ff @(posedge clk)
    begin
        if (cmd.point)
        begin
            logic [17:0] tn;
            tn = 18'({7'(k_reg) + 7'd1, 10'd0});
            if (single_reg || (7'(k_reg) + 7'd1 == len_reg))
                seg_reg <= 2'd0;
            else if (!kind_reg)
                seg_reg <= (tn < 18'(raw_reg)) ? 2'd1 : 2'd0;
            else if (tn <= 18'(raw_reg))
                seg_reg <= 2'd2;
            else if (tn < 18'(x2))
                seg_reg <= 2'd3;
            else
                seg_reg <= 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg   <= '0;
            scnt_reg   <= '0;
            k_reg      <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.div_start)
                dcnt_reg <= '0;
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg + 6'd1;
            if (cmd.sqrt_start)
                scnt_reg <= '0;
            else if (cmd.sqrt_step)
                scnt_reg <= scnt_reg + 5'd1;
            if (cmd.load)
                k_reg <= '0;
            else if (cmd.emit)
                k_reg <= k_reg + 6'd1;
        end
    end

    assign dout   = out_reg;
    assign strobe = strobe_reg;

    property p_one_strobe;
        @(posedge clk) disable iff (!rst_n)
        cmd.emit |=> strobe;
    endproperty
    a_one_strobe: assert property (p_one_strobe) else $error("strobe missing");

    property p_pos_follows;
        @(posedge clk) disable iff (!rst_n)
        (strobe && !dout.last) |-> (k_reg == dout.position + 6'd1);
    endproperty
    a_pos_follows: assert property (p_pos_follows) else $error("position skip");

    property p_last_one;
        @(posedge clk) disable iff (!rst_n)
        (strobe && dout.last) |-> (prev_reg == ONE_OUT);
    endproperty
    a_last_one: assert property (p_last_one) else $error("sum not one");
endmodule
`default_nettype wire

[rtl/core/unit_hydrograph_ordinates_unit.sv]
// Top level of the unit hydrograph ordinate generator.
// Depends on uho_pkg, uho_ctrl and uho_dp.
//
// Usage: present an input beat (action, x4_days) with start high while busy is
// low; the beat is taken on that edge. The block then emits the curve's
// ordinates in order, one result beat per strobe pulse, each carrying the
// ordinate (Q1.16), its position and a last flag. The receiver cannot stall:
// each result is valid only in the cycle strobe is high.
// 1/x4 is formed first by a one-bit-per-cycle divider. Each ordinate then
// passes the point and u-multiply steps; where S is not fixed and the 2.5
// power is formed, it then also passes the 24-step square root unit and the
// u^2 and power multiplies. busy stays high until the last result.
// Reset clears the controller to idle; no result is pending after reset.
`default_nettype none
module unit_hydrograph_ordinates_unit #(
    parameter int MAX_ORDINATES = 64,
    parameter int ORD_FRAC_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire uho_pkg::uho_in_t  din,
    output logic                   busy,
    output logic                   strobe,
    output uho_pkg::uho_out_t      result
);
    import uho_pkg::*;

    uho_cmd_t cmd;
    uho_sts_t sts;

    uho_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    uho_dp #(
        .MAX_ORDINATES (MAX_ORDINATES),
        .ORD_FRAC_BITS (ORD_FRAC_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .din    (din),
        .cmd    (cmd),
        .sts    (sts),
        .dout   (result),
        .strobe (strobe)
    );
endmodule
`default_nettype wire

[tb/unit_hydrograph_ordinates_unit_tb.sv]
// Testbench for the unit hydrograph ordinate generator.
// Depends on uho_pkg and unit_hydrograph_ordinates_unit; predicts each curve
// in fixed point and checks every ordinate beat in order.
`timescale 1ns / 100ps
`default_nettype none
module unit_hydrograph_ordinates_unit_tb;
    import uho_pkg::*;

    localparam int MAX_ORD   = 64;
    localparam int WATCHDOG  = 20000;
    localparam int N_RANDOM  = 250;
    localparam logic KIND_ONE_SIDED = 1'b0;
    localparam logic KIND_TWO_SIDED = 1'b1;

    logic     clk;
    logic     rst_n;
    logic     start;
    uho_in_t  din;
    logic     busy;
    logic     strobe;
    uho_out_t result;

    uho_in_t  pending_curves[$];
    uho_out_t expected_ordinates[$];
    int       gap_left;
    int       idle_cycles;
    int       error_count;
    bit       stim_done;

    unit_hydrograph_ordinates_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .din    (din),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // u in Q.23, clamped to 1.0; returns u^2.5 in Q.23
    function automatic logic [63:0] power_2p5(input logic [63:0] u);
        logic [63:0] u2;
        if (u > (64'd1 << WFRAC))
            u = 64'd1 << WFRAC;
        u2 = (u * u) >> WFRAC;
        return (u2 * int_sqrt(u << WFRAC)) >> WFRAC;
    endfunction

    task automatic predict_curve(input uho_in_t beat);
        logic [31:0] raw;
        logic [31:0] len;
        logic [31:0] recip;
        logic [63:0] s24;
        logic [63:0] u;
        logic [63:0] tq;
        logic [31:0] s;
        logic [31:0] prev_s;
        bit          single;
        uho_out_t    ord;
        raw = beat.x4_days;
        if (raw > X4_MAX)
            raw = X4_MAX;
        single = (beat.action == KIND_TWO_SIDED) ? (raw <= 512) : (raw <= 1024);
        if (single)
        begin
            len = 1;
            recip = 0;
        end
        else
        begin
            len = (raw + 1023) >> 10;
            if (beat.action == KIND_TWO_SIDED)
                len = len * 2;
            recip = ((64'd1 << 33) / raw) & 32'hFFFFFF;
        end
        if (len > MAX_ORD)
            len = MAX_ORD;
        prev_s = 0;
        for (int k = 0; k < len; k++)
        begin
            tq = (k + 1) * 1024;
            u = (k + 1) * recip;
            if (beat.action == KIND_ONE_SIDED)
                s24 = (tq < raw) ? (power_2p5(u) << 1) : (64'd1 << 24);
            else if (tq <= raw)
                s24 = power_2p5(u);
            else if (tq < 2 * raw)
                s24 = (64'd1 << 24)
                    - power_2p5((u < (64'd2 << WFRAC)) ? (64'd2 << WFRAC) - u : 0);
            else
                s24 = 64'd1 << 24;
            s = (k + 1 == len) ? 32'd65536 : 32'((s24 + 128) >> 8);
            ord.ordinate = (s >= prev_s) ? 17'(s - prev_s) : 17'd0;
            ord.position = 6'(k);
            ord.last = (k + 1 == len);
            prev_s = s;
            expected_ordinates.push_back(ord);
        end
    endtask

    function automatic uho_in_t make_curve(input logic kind, input logic [15:0] x4);
        uho_in_t b;
        b.action = kind;
        b.x4_days = x4;
        return b;
    endfunction

    initial
    begin
        uho_in_t b;
        // extremes, small-time-base cases, half-day band, exact boundaries, saturation
        pending_curves.push_back(make_curve(KIND_ONE_SIDED, 16'd0));
        pending_curves.push_back(make_curve(KIND_TWO_SIDED, 16'd0));
        pending_curves.push_back(make_curve(KIND_ONE_SIDED, 16'd1024));
        pending_curves.push_back(make_curve(KIND_ONE_SIDED, 16'd1025));
        pending_curves.push_back(make_curve(KIND_TWO_SIDED, 16'd512));
        pending_curves.push_back(make_curve(KIND_TWO_SIDED, 16'd513));
        pending_curves.push_back(make_curve(KIND_TWO_SIDED, 16'd1024));
        pending_curves.push_back(make_curve(KIND_TWO_SIDED, 16'd777));
        pending_curves.push_back(make_curve(KIND_ONE_SIDED, 16'd2048));
        pending_curves.push_back(make_curve(KIND_TWO_SIDED, 16'd3072));
        pending_curves.push_back(make_curve(KIND_ONE_SIDED, 16'd5000));
        pending_curves.push_back(make_curve(KIND_TWO_SIDED, 16'd5000));
        pending_curves.push_back(make_curve(KIND_ONE_SIDED, 16'd32767));
        pending_curves.push_back(make_curve(KIND_ONE_SIDED, 16'd32768));
        pending_curves.push_back(make_curve(KIND_TWO_SIDED, 16'd32768));
        pending_curves.push_back(make_curve(KIND_TWO_SIDED, 16'd32769));
        pending_curves.push_back(make_curve(KIND_ONE_SIDED, 16'hFFFF));
        pending_curves.push_back(make_curve(KIND_TWO_SIDED, 16'hFFFF));
        pending_curves.push_back(make_curve(KIND_TWO_SIDED, 16'd33 * 1024));
        pending_curves.push_back(make_curve(KIND_ONE_SIDED, 16'h5555));
        pending_curves.push_back(make_curve(KIND_TWO_SIDED, 16'h2AAA));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            b.action = 1'($urandom);
            case ($urandom_range(0, 9))
                0: b.x4_days = 16'($urandom);
                1: b.x4_days = 16'($urandom_range(0, 1100));
                2: b.x4_days = 16'($urandom_range(8192, 32768));
                default: b.x4_days = 16'($urandom_range(1025, 8192));
            endcase
            pending_curves.push_back(b);
        end
    end

    // driver: one beat per start, random gap before each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            din <= '0;
            gap_left <= $urandom_range(0, 18);
            stim_done <= 1'b0;
        end
        else if (start && !busy)
        begin
            predict_curve(din);
            start <= 1'b0;
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        end
        else if (!start)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_curves.size() > 0)
            begin
                din <= pending_curves.pop_front();
                start <= 1'b1;
            end
            else
                stim_done <= 1'b1;
        end
    end

    // monitor and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        uho_out_t exp_ord;
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if (strobe)
            begin
                if (expected_ordinates.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, result);
                    error_count++;
                end
                else
                begin
                    exp_ord = expected_ordinates.pop_front();
                    if (result.ordinate !== exp_ord.ordinate)
                    begin
                        $display("%0t: ordinate expected %0d actual %0d", $time,
                                 exp_ord.ordinate, result.ordinate);
                        error_count++;
                    end
                    if (result.position !== exp_ord.position)
                    begin
                        $display("%0t: position expected %0d actual %0d", $time,
                                 exp_ord.position, result.position);
                        error_count++;
                    end
                    if (result.last !== exp_ord.last)
                    begin
                        $display("%0t: last expected %0b actual %0b", $time,
                                 exp_ord.last, result.last);
                        error_count++;
                    end
                end
            end
            if (strobe || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("** unit_hydrograph_ordinates_unit: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        error_count = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && expected_ordinates.size() == 0);
        repeat (100) @(posedge clk);
        if (error_count == 0 && expected_ordinates.size() == 0)
            $display("** unit_hydrograph_ordinates_unit: PASSED **");
        else
            $display("** unit_hydrograph_ordinates_unit: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
